@@ rtl/g2e_pkg.sv @@
// Shared constants, tables, types and helper functions for the geodetic to ECEF datapath.
package g2e_pkg;

  localparam logic [1:0] CFG_AXIS = 2'd0;
  localparam logic [1:0] CFG_ECC  = 2'd1;

  localparam logic [32:0] AXIS_RESET = 33'd6378137000;
  localparam logic [26:0] ECC_RESET  = 27'd28752143;

  localparam logic [63:0] Q62_ONE   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] Q62_THREE = 64'hC000_0000_0000_0000;

  localparam logic [32:0] DEG45  = 33'd754974720;
  localparam logic [32:0] DEG90  = 33'd1509949440;
  localparam logic [32:0] DEG180 = 33'd3019898880;
  localparam logic [32:0] DEG270 = 33'd4529848320;
  localparam logic [32:0] DEG360 = 33'd6039797760;
  localparam logic [63:0] RAD_PER_DEG = 64'd80489105089745813;

  localparam logic [33:0] OUT_LIMIT = 34'd8000000000;
  localparam logic signed [33:0] OUT_MAX = 34'sd8000000000;
  localparam logic signed [33:0] OUT_MIN = -34'sd8000000000;

  localparam int SIN_STEPS    = 7;
  localparam int COS_STEPS    = 8;
  localparam int NEWTON_STEPS = 6;

  // sincos internal alignment
  localparam int SC_X_DLY  = 44;
  localparam int SC_S0_DLY = 4;
  localparam int SC_QS_DLY = 53;

  // top level alignment
  localparam int H_DLY    = 106;
  localparam int SL_DLY   = 52;
  localparam int CN_DLY   = 55;
  localparam int N_DLY    = 2;
  localparam int Z_DLY    = 3;
  localparam int PIPE_LAT = 114;

  localparam logic [64:0] TWO64 = {1'b1, 64'd0};

  localparam logic [7:0] SIN_DEN [SIN_STEPS] = '{
    8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [63:0] SIN_RECIP [SIN_STEPS] = '{
    64'(TWO64 / 65'd210), 64'(TWO64 / 65'd156), 64'(TWO64 / 65'd110),
    64'(TWO64 / 65'd72), 64'(TWO64 / 65'd42), 64'(TWO64 / 65'd20),
    64'(TWO64 / 65'd6)
  };
  localparam logic [7:0] COS_DEN [COS_STEPS] = '{
    8'd240, 8'd182, 8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2
  };
  localparam logic [63:0] COS_RECIP [COS_STEPS] = '{
    64'(TWO64 / 65'd240), 64'(TWO64 / 65'd182), 64'(TWO64 / 65'd132),
    64'(TWO64 / 65'd90), 64'(TWO64 / 65'd56), 64'(TWO64 / 65'd30),
    64'(TWO64 / 65'd12), 64'(TWO64 / 65'd2)
  };

  typedef struct packed {
    logic [63:0] sn;
    logic [63:0] cs;
  } trig_t;

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [33:0] to_mm(input logic [63:0] v);
    logic [63:0] m;
    logic [47:0] mh;
    logic [33:0] sat;
    m   = mag64(v) + 64'd32768;
    mh  = m[63:16];
    sat = (mh > {14'd0, OUT_LIMIT}) ? OUT_LIMIT : mh[33:0];
    return v[63] ? (~sat + 34'd1) : sat;
  endfunction

endpackage

@@ rtl/geodetic_to_ecef.sv @@
// Top level: geodetic latitude, longitude and height to ECEF coordinates in millimetres.
//
// Input channel (in_valid_i/in_ready_o) takes one point per item: latitude and
// longitude in degrees with 24 fraction bits, height in mm. Output channel
// (out_valid_o/out_ready_i) returns x, y, z in mm, rounded and saturated to
// +-8000000000. Configuration channel (cfg_valid_i/cfg_ready_o) writes the
// semi-major axis (index 0) and eccentricity squared (index 1); it is always
// ready, and writes belong only to idle periods.
// One item per cycle is taken while the receiver does not stall. The pipeline
// depth is set by the chain of two-stage 64-bit multipliers:
// the sine/cosine series, six Newton steps of the inverse square root and
// the final scaling products.
// Reset clears the pipeline valid bits and loads the WGS84 axis and
// eccentricity. When the receiver stalls, the whole pipeline holds and
// in_ready_o drops; no item is lost or repeated.
module geodetic_to_ecef (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [32:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] latitude_deg_i,
  input  logic signed [32:0] longitude_deg_i,
  input  logic signed [27:0] height_mm_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [33:0] ecef_x_mm_o,
  output logic signed [33:0] ecef_y_mm_o,
  output logic signed [33:0] ecef_z_mm_o
);
  import g2e_pkg::*;

  logic                en;
  logic [PIPE_LAT-1:0] valid_q;
  logic [32:0]         axis_q;
  logic [26:0]         ecc_q;
  trig_t               lat_trig, lon_trig;
  trig_t               lat_q [SL_DLY];
  trig_t               lon_q [CN_DLY];
  logic [27:0]         h_q [H_DLY];
  logic [63:0]         n_q [N_DLY];
  logic [63:0]         z_q [Z_DLY];
  logic [127:0]        ps2, pw, pn, pnb;
  logic [63:0]         w_q, n, h64, rad_q, rz_q, p, pz, px, py;
  logic [63:0]         nw_w [NEWTON_STEPS+1];
  logic [63:0]         nw_y [NEWTON_STEPS+1];
  logic [33:0]         x_q, y_q, zo_q;

  assign en          = out_ready_i || !out_valid_o;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = valid_q[PIPE_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      axis_q  <= AXIS_RESET;
      ecc_q   <= ECC_RESET;
    end else begin
      if (en) begin
        valid_q <= {valid_q[PIPE_LAT-2:0], in_valid_i};
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_AXIS: axis_q <= cfg_data_i;
          CFG_ECC:  ecc_q  <= cfg_data_i[26:0];
          default:  ;
        endcase
      end
    end
  end

  g2e_sincos u_lat (.clk_i(clk_i), .en_i(en), .deg_i({latitude_deg_i[31], latitude_deg_i}),
                    .trig_o(lat_trig));
  g2e_sincos u_lon (.clk_i(clk_i), .en_i(en), .deg_i(longitude_deg_i), .trig_o(lon_trig));

  g2e_mul64 u_mul_s2 (.clk_i(clk_i), .en_i(en), .a_i(mag64(lat_trig.sn)),
                      .b_i(mag64(lat_trig.sn)), .p_o(ps2));
  g2e_mul64 u_mul_w (.clk_i(clk_i), .en_i(en), .a_i({7'd0, ecc_q, 30'd0}),
                     .b_i(ps2[125:62]), .p_o(pw));

  assign nw_w[0] = w_q;
  assign nw_y[0] = Q62_ONE;

  for (genvar i = 0; i < NEWTON_STEPS; i++) begin : g_newton
    g2e_nstep u_step (.clk_i(clk_i), .en_i(en), .w_i(nw_w[i]), .y_i(nw_y[i]),
                      .w_o(nw_w[i+1]), .y_o(nw_y[i+1]));
  end

  g2e_mul64 u_mul_n (.clk_i(clk_i), .en_i(en), .a_i({31'd0, axis_q}),
                     .b_i(nw_y[NEWTON_STEPS]), .p_o(pn));
  assign n = pn[109:46];
  g2e_mul64 u_mul_nb (.clk_i(clk_i), .en_i(en), .a_i(n),
                      .b_i(64'h1_0000_0000 - {37'd0, ecc_q}), .p_o(pnb));

  assign h64 = {{20{h_q[H_DLY-1][27]}}, h_q[H_DLY-1], 16'd0};

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q <= Q62_ONE - pw[125:62];
      h_q[0] <= height_mm_i;
      for (int k = 1; k < H_DLY; k++) h_q[k] <= h_q[k-1];
      lat_q[0] <= lat_trig;
      for (int k = 1; k < SL_DLY; k++) lat_q[k] <= lat_q[k-1];
      lon_q[0] <= lon_trig;
      for (int k = 1; k < CN_DLY; k++) lon_q[k] <= lon_q[k-1];
      n_q[0] <= n;
      for (int k = 1; k < N_DLY; k++) n_q[k] <= n_q[k-1];
      rad_q <= n_q[N_DLY-1] + h64;
      rz_q  <= pnb[95:32] + h64;
      z_q[0] <= pz;
      for (int k = 1; k < Z_DLY; k++) z_q[k] <= z_q[k-1];
      x_q  <= to_mm(px);
      y_q  <= to_mm(py);
      zo_q <= to_mm(z_q[Z_DLY-1]);
    end
  end

  g2e_smul u_smul_p (.clk_i(clk_i), .en_i(en), .a_i(rad_q), .b_i(lat_q[SL_DLY-1].cs),
                     .p_o(p));
  g2e_smul u_smul_z (.clk_i(clk_i), .en_i(en), .a_i(rz_q), .b_i(lat_q[SL_DLY-1].sn),
                     .p_o(pz));
  g2e_smul u_smul_x (.clk_i(clk_i), .en_i(en), .a_i(p), .b_i(lon_q[CN_DLY-1].cs),
                     .p_o(px));
  g2e_smul u_smul_y (.clk_i(clk_i), .en_i(en), .a_i(p), .b_i(lon_q[CN_DLY-1].sn),
                     .p_o(py));

  assign ecef_x_mm_o = x_q;
  assign ecef_y_mm_o = y_q;
  assign ecef_z_mm_o = zo_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (ecef_x_mm_o <= OUT_MAX) && (ecef_x_mm_o >= OUT_MIN)
                 && (ecef_y_mm_o <= OUT_MAX) && (ecef_y_mm_o >= OUT_MIN)
                 && (ecef_z_mm_o <= OUT_MAX) && (ecef_z_mm_o >= OUT_MIN))
    else $error("coordinate outside saturation range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("pipeline valid bits moved during stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i == CFG_AXIS) |=> axis_q == $past(cfg_data_i))
    else $error("axis register write lost");

endmodule

@@ rtl/g2e_mul64.sv @@
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module g2e_mul64 (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic [127:0] p_o
);

  logic [63:0]  p00_q, p01_q, p10_q, p11_q;
  logic [127:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q <= a_i[31:0] * b_i[31:0];
      p01_q <= a_i[31:0] * b_i[63:32];
      p10_q <= a_i[63:32] * b_i[31:0];
      p11_q <= a_i[63:32] * b_i[63:32];
      p_q   <= {64'd0, p00_q} + ({64'd0, p01_q} << 32) + ({64'd0, p10_q} << 32)
             + {p11_q, 64'd0};
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/g2e_hstep.sv @@
// One Horner step of the sine or cosine series: t' = 1 - (x2*t)/den, six stages.
module g2e_hstep (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x2_i,
  input  logic [63:0] t_i,
  input  logic [7:0]  den_i,
  input  logic [63:0] recip_i,
  output logic [63:0] x2_o,
  output logic [63:0] t_o
);
  import g2e_pkg::*;

  logic [127:0] pa, pb;
  logic [63:0]  v;
  logic [63:0]  v_q [2];
  logic [63:0]  x2_q [6];
  logic [63:0]  q0_q, r_q, t_q;

  g2e_mul64 u_mul_a (.clk_i(clk_i), .en_i(en_i), .a_i(x2_i), .b_i(t_i), .p_o(pa));

  assign v = pa[125:62];

  g2e_mul64 u_mul_b (.clk_i(clk_i), .en_i(en_i), .a_i(v), .b_i(recip_i), .p_o(pb));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0]  <= v;
      v_q[1]  <= v_q[0];
      x2_q[0] <= x2_i;
      for (int k = 1; k < 6; k++) x2_q[k] <= x2_q[k-1];
      q0_q <= pb[127:64];
      r_q  <= v_q[1] - pb[127:64] * {56'd0, den_i};
      t_q  <= Q62_ONE - q0_q - {63'd0, (r_q >= {56'd0, den_i})};
    end
  end

  assign x2_o = x2_q[5];
  assign t_o  = t_q;

endmodule

@@ rtl/g2e_nstep.sv @@
// One Newton step of the inverse square root: y' = y*(3 - w*y*y)/2, seven stages.
module g2e_nstep (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] w_i,
  input  logic [63:0] y_i,
  output logic [63:0] w_o,
  output logic [63:0] y_o
);
  import g2e_pkg::*;

  logic [127:0] pyy, pt, py;
  logic [63:0]  w_q [7];
  logic [63:0]  y_q [5];
  logic [63:0]  u_q;

  g2e_mul64 u_mul_yy (.clk_i(clk_i), .en_i(en_i), .a_i(y_i), .b_i(y_i), .p_o(pyy));
  g2e_mul64 u_mul_t (.clk_i(clk_i), .en_i(en_i), .a_i(w_q[1]), .b_i(pyy[125:62]),
                     .p_o(pt));
  g2e_mul64 u_mul_y (.clk_i(clk_i), .en_i(en_i), .a_i(y_q[4]), .b_i(u_q), .p_o(py));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q[0] <= w_i;
      for (int k = 1; k < 7; k++) w_q[k] <= w_q[k-1];
      y_q[0] <= y_i;
      for (int k = 1; k < 5; k++) y_q[k] <= y_q[k-1];
      u_q <= Q62_THREE - pt[125:62];
    end
  end

  assign w_o = w_q[6];
  assign y_o = py[126:63];

endmodule

@@ rtl/g2e_smul.sv @@
// Signed Q62 product truncated toward zero, three stages.
module g2e_smul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);
  import g2e_pkg::*;

  logic [127:0] pm;
  logic [1:0]   neg_q;
  logic [63:0]  p_q;

  g2e_mul64 u_mul (.clk_i(clk_i), .en_i(en_i), .a_i(mag64(a_i)), .b_i(mag64(b_i)),
                   .p_o(pm));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q <= {neg_q[0], a_i[63] ^ b_i[63]};
      p_q   <= neg_q[1] ? (~pm[125:62] + 64'd1) : pm[125:62];
    end
  end

  assign p_o = p_q;

endmodule

@@ rtl/g2e_sincos.sv @@
// Pipelined sine and cosine in Q62 of an angle in degrees with 24 fraction bits.
module g2e_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [32:0]        deg_i,
  output g2e_pkg::trig_t     trig_o
);
  import g2e_pkg::*;

  logic [32:0]  a_q, a_d, rr;
  logic [1:0]   q_d;
  logic [32:0]  base;
  logic         swap_d;
  logic [29:0]  r_q;
  logic [2:0]   qs_q [SC_QS_DLY];
  logic [127:0] px, px2, ps0;
  logic [63:0]  x, x2;
  logic [63:0]  x_q [SC_X_DLY];
  logic [63:0]  s0_q [SC_S0_DLY];
  logic [63:0]  sx2 [SIN_STEPS+1];
  logic [63:0]  st [SIN_STEPS+1];
  logic [63:0]  cx2 [COS_STEPS+1];
  logic [63:0]  ct [COS_STEPS+1];
  logic [63:0]  s0, c0, sw_s, sw_c;
  trig_t        trig_q;

  always_comb begin
    a_d = deg_i[32] ? 33'({deg_i[32], deg_i} + {1'b0, DEG360}) : deg_i;
    if (a_q >= DEG270) begin
      q_d = 2'd3; base = DEG270;
    end else if (a_q >= DEG180) begin
      q_d = 2'd2; base = DEG180;
    end else if (a_q >= DEG90) begin
      q_d = 2'd1; base = DEG90;
    end else begin
      q_d = 2'd0; base = 33'd0;
    end
    rr     = a_q - base;
    swap_d = rr > DEG45;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q <= a_d;
      r_q <= swap_d ? 30'(DEG90 - rr) : rr[29:0];
      qs_q[0] <= {q_d, swap_d};
      for (int k = 1; k < SC_QS_DLY; k++) qs_q[k] <= qs_q[k-1];
      x_q[0] <= x;
      for (int k = 1; k < SC_X_DLY; k++) x_q[k] <= x_q[k-1];
      s0_q[0] <= ps0[125:62];
      for (int k = 1; k < SC_S0_DLY; k++) s0_q[k] <= s0_q[k-1];
      trig_q <= '{sn: sw_s, cs: sw_c};
    end
  end

  g2e_mul64 u_mul_x (.clk_i(clk_i), .en_i(en_i), .a_i({34'd0, r_q}), .b_i(RAD_PER_DEG),
                     .p_o(px));
  assign x = px[87:24];
  g2e_mul64 u_mul_x2 (.clk_i(clk_i), .en_i(en_i), .a_i(x), .b_i(x), .p_o(px2));
  assign x2 = px2[125:62];

  assign sx2[0] = x2;
  assign st[0]  = Q62_ONE;
  assign cx2[0] = x2;
  assign ct[0]  = Q62_ONE;

  for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
    g2e_hstep u_step (.clk_i(clk_i), .en_i(en_i), .x2_i(sx2[i]), .t_i(st[i]),
                      .den_i(SIN_DEN[i]), .recip_i(SIN_RECIP[i]),
                      .x2_o(sx2[i+1]), .t_o(st[i+1]));
  end

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
    g2e_hstep u_step (.clk_i(clk_i), .en_i(en_i), .x2_i(cx2[i]), .t_i(ct[i]),
                      .den_i(COS_DEN[i]), .recip_i(COS_RECIP[i]),
                      .x2_o(cx2[i+1]), .t_o(ct[i+1]));
  end

  g2e_mul64 u_mul_s0 (.clk_i(clk_i), .en_i(en_i), .a_i(x_q[SC_X_DLY-1]),
                      .b_i(st[SIN_STEPS]), .p_o(ps0));

  always_comb begin
    s0 = qs_q[SC_QS_DLY-1][0] ? ct[COS_STEPS] : s0_q[SC_S0_DLY-1];
    c0 = qs_q[SC_QS_DLY-1][0] ? s0_q[SC_S0_DLY-1] : ct[COS_STEPS];
    case (qs_q[SC_QS_DLY-1][2:1])
      2'd0: begin sw_s = s0;            sw_c = c0;            end
      2'd1: begin sw_s = c0;            sw_c = ~s0 + 64'd1;   end
      2'd2: begin sw_s = ~s0 + 64'd1;   sw_c = ~c0 + 64'd1;   end
      default: begin sw_s = ~c0 + 64'd1; sw_c = s0;          end
    endcase
  end

  assign trig_o = trig_q;

endmodule

@@ tb/tb_geodetic_to_ecef.sv @@
// Self-checking testbench for geodetic_to_ecef: directed and random points and settings against a predictor.
`timescale 1ns / 100ps

module tb_geodetic_to_ecef;
  import g2e_pkg::*;

  typedef struct {
    logic signed [31:0] lat;
    logic signed [32:0] lon;
    logic signed [27:0] hgt;
  } point_t;

  typedef struct {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } ecef_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [32:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] latitude_deg_i = '0;
  logic signed [32:0] longitude_deg_i = '0;
  logic signed [27:0] height_mm_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [33:0] ecef_x_mm_o;
  logic signed [33:0] ecef_y_mm_o;
  logic signed [33:0] ecef_z_mm_o;

  point_t      pending_points[$];
  ecef_t       expected_coords[$];
  logic [32:0] axis_mm = AXIS_RESET;
  logic [26:0] ecc_q32 = ECC_RESET;
  bit          no_idle = 1'b0;
  int          errors = 0;
  int          in_gap = 0;
  int          out_stall = 0;

  geodetic_to_ecef i_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    return p[63:0];
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint mul_signed(longint a, longint b, int s);
    logic [63:0] r;
    r = mul_shr(magnitude(a), magnitude(b), s);
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void trig_of_deg(input longint deg, output longint sn,
                                      output longint cs);
    longint      a;
    longint      q;
    longint      r;
    logic [63:0] x, x2, t, s0, c0, tmp;
    bit          swap;
    a = deg % longint'(DEG360);
    if (a < 0) a += longint'(DEG360);
    q = a / longint'(DEG90);
    r = a - q * longint'(DEG90);
    swap = r > longint'(DEG45);
    if (swap) r = longint'(DEG90) - r;
    x  = mul_shr(64'(r), RAD_PER_DEG, 24);
    x2 = mul_shr(x, x, 62);
    t = Q62_ONE;
    for (int i = 0; i < SIN_STEPS; i++) t = Q62_ONE - mul_shr(x2, t, 62) / 64'(SIN_DEN[i]);
    s0 = mul_shr(x, t, 62);
    t = Q62_ONE;
    for (int i = 0; i < COS_STEPS; i++) t = Q62_ONE - mul_shr(x2, t, 62) / 64'(COS_DEN[i]);
    c0 = t;
    if (swap) begin
      tmp = s0; s0 = c0; c0 = tmp;
    end
    case (q)
      0: begin sn = longint'(s0);  cs = longint'(c0);  end
      1: begin sn = longint'(c0);  cs = -longint'(s0); end
      2: begin sn = -longint'(s0); cs = -longint'(c0); end
      default: begin sn = -longint'(c0); cs = longint'(s0); end
    endcase
  endfunction

  function automatic logic [33:0] round_sat_mm(longint v);
    logic [63:0] m;
    logic [63:0] r;
    m = (magnitude(v) + 64'd32768) >> 16;
    if (m > 64'(OUT_LIMIT)) m = 64'(OUT_LIMIT);
    r = (v < 0) ? -m : m;
    return r[33:0];
  endfunction

  function automatic ecef_t geodetic_to_ecef_mm(point_t pt);
    longint      sl, cl, sn, cn, h, rad, rz, p;
    logic [63:0] s2, w, y, n, nb;
    ecef_t       res;
    trig_of_deg(longint'(pt.lat), sl, cl);
    trig_of_deg(longint'(pt.lon), sn, cn);
    h  = longint'(pt.hgt) * 65536;
    s2 = mul_shr(magnitude(sl), magnitude(sl), 62);
    w  = Q62_ONE - mul_shr({37'd0, ecc_q32} << 30, s2, 62);
    y  = Q62_ONE;
    for (int i = 0; i < NEWTON_STEPS; i++)
      y = mul_shr(y, Q62_THREE - mul_shr(w, mul_shr(y, y, 62), 62), 63);
    n   = mul_shr({31'd0, axis_mm}, y, 46);
    nb  = mul_shr(n, (64'd1 << 32) - {37'd0, ecc_q32}, 32);
    rad = longint'(n) + h;
    rz  = longint'(nb) + h;
    p   = mul_signed(rad, cl, 62);
    res.x = round_sat_mm(mul_signed(p, cn, 62));
    res.y = round_sat_mm(mul_signed(p, sn, 62));
    res.z = round_sat_mm(mul_signed(rz, sl, 62));
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap = 0;
    end else begin : drive
      point_t pt;
      logic   nxt;
      nxt = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        pt.lat = latitude_deg_i;
        pt.lon = longitude_deg_i;
        pt.hgt = height_mm_i;
        expected_coords.push_back(geodetic_to_ecef_mm(pt));
        nxt = 1'b0;
        in_gap = no_idle ? 0 : $urandom_range(0, 16);
      end
      if (!nxt) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_points.size() > 0) begin
          pt = pending_points.pop_front();
          latitude_deg_i  <= pt.lat;
          longitude_deg_i <= pt.lon;
          height_mm_i     <= pt.hgt;
          nxt = 1'b1;
        end
      end
      in_valid_i <= nxt;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_stall = 0;
    end else begin : monitor
      ecef_t exp_c;
      logic  nxt;
      nxt = out_ready_i;
      if (out_valid_o && out_ready_i) begin
        if (expected_coords.size() == 0) begin
          $error("unexpected result x=%0d y=%0d z=%0d", ecef_x_mm_o, ecef_y_mm_o, ecef_z_mm_o);
          errors++;
        end else begin
          exp_c = expected_coords.pop_front();
          if (ecef_x_mm_o !== exp_c.x) begin
            $error("ecef_x_mm: expected %0d, got %0d", exp_c.x, ecef_x_mm_o);
            errors++;
          end
          if (ecef_y_mm_o !== exp_c.y) begin
            $error("ecef_y_mm: expected %0d, got %0d", exp_c.y, ecef_y_mm_o);
            errors++;
          end
          if (ecef_z_mm_o !== exp_c.z) begin
            $error("ecef_z_mm: expected %0d, got %0d", exp_c.z, ecef_z_mm_o);
            errors++;
          end
        end
        out_stall = no_idle ? 0 : $urandom_range(0, 16);
        nxt = (out_stall == 0);
      end else if (!out_ready_i) begin
        if (out_stall > 0) out_stall--;
        nxt = (out_stall == 0);
      end
      out_ready_i <= nxt;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [32:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_AXIS) axis_mm = data;
    else if (idx == CFG_ECC) ecc_q32 = data[26:0];
    cfg_valid_i <= 1'b0;
  endtask

  task automatic add_point(input longint lat, input longint lon, input longint hgt);
    point_t pt;
    pt.lat = 32'(lat);
    pt.lon = 33'(lon);
    pt.hgt = 28'(hgt);
    pending_points.push_back(pt);
  endtask

  task automatic add_random_points(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0)
        add_point($urandom, {$urandom, $urandom}, $urandom);
      else
        add_point(longint'($urandom_range(0, 32'd3019898880)) - longint'(DEG90),
                  longint'($urandom_range(0, 32'd3019898880)) * 2 - longint'(DEG180),
                  longint'($urandom_range(0, 200000000)) - 100000000);
    end
  endtask

  task automatic drain;
    do @(negedge clk_i);
    while (pending_points.size() != 0 || in_valid_i || expected_coords.size() != 0);
    repeat (PIPE_LAT + 16) @(posedge clk_i);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_point(0, 0, 0);
    add_point(longint'(DEG90), 0, 0);
    add_point(-longint'(DEG90), 0, 0);
    add_point(longint'(DEG45), longint'(DEG45), 1000);
    add_point(-longint'(DEG45), -longint'(DEG90), -1000);
    add_point(0, longint'(DEG180), 100000000);
    add_point(0, -longint'(DEG180), -100000000);
    add_point(0, longint'(DEG270), 0);
    add_point(0, longint'(DEG360), 0);
    add_point(2147483647, 64'sd4294967295, 134217727);
    add_point(-2147483648, -64'sd4294967296, -134217728);
    add_point(longint'(DEG90) + 1, longint'(DEG180) + 1, 1);
    add_point(-longint'(DEG90) - 1, -longint'(DEG180) - 1, -1);
    add_point(-1, -1, -1);
    add_point(1, 1, 1);
    drain();

    write_reg(CFG_AXIS, 33'd0);
    write_reg(CFG_ECC, 27'h7FFFFFF);
    add_point(longint'(DEG45), 0, -100000000);
    add_point(longint'(DEG90), longint'(DEG90), -134217728);
    add_point(0, 0, 100);
    add_random_points(30);
    drain();

    write_reg(CFG_AXIS, 33'h1FFFFFFFF);
    write_reg(CFG_ECC, 27'd0);
    write_reg(2'd2, 33'd12345);
    write_reg(2'd3, 33'h1FFFFFFFF);
    add_point(0, 0, 134217727);
    add_point(longint'(DEG90), 0, 134217727);
    add_point(0, longint'(DEG90), 0);
    add_random_points(100);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      no_idle = ph[0];
      case ($urandom_range(0, 3))
        0: write_reg(CFG_AXIS, 33'd1);
        1: write_reg(CFG_AXIS, {$urandom, 1'b0} | 33'(ph));
        default: write_reg(CFG_AXIS, 33'(64'd6000000000 + 64'($urandom_range(0, 1000000000))));
      endcase
      write_reg(CFG_ECC, ph == 9 ? 33'(ECC_RESET) : 33'($urandom_range(0, 67108864)));
      add_random_points(130);
      drain();
    end

    if (errors == 0) begin
      $display("[geodetic_to_ecef] OK");
    end else begin
      $display("[geodetic_to_ecef] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[geodetic_to_ecef] ERROR");
    $finish;
  end

endmodule
